### hw/rtl/motor_command_frame_packer_macros.svh
// ----------------------------------------------------------------------------
// Motor command frame packer assertion macros
// Shared concurrent assertion forms for the packer RTL.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_PACKER_MACROS_SVH
`define MOTOR_COMMAND_FRAME_PACKER_MACROS_SVH

// same-cycle implication
`define MCFP_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCFP_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mcfp_pkg.sv
// ----------------------------------------------------------------------------
// Motor command frame packer package
// Widths, lane numbering, register indexes and pipeline stage types.
// ----------------------------------------------------------------------------
package mcfp_pkg;

  localparam int POSITION_BITS = 16;
  localparam int GAIN_BITS     = 12;
  localparam int QUO_W         = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;
  localparam int NUM_STEPS     = QUO_W;
  localparam int DATA_W        = 32;
  localparam int LIMIT_W       = 31;
  localparam int SPAN_W        = DATA_W + 1;
  localparam int DIFF_W        = SPAN_W + 1;
  localparam int NUM_W         = SPAN_W + QUO_W;
  localparam int CODE_W        = 16;
  localparam int NUM_LANES     = 5;
  localparam int BYTE_W        = 8;

  localparam int LANE_POS   = 0;
  localparam int LANE_VEL   = 1;
  localparam int LANE_STIFF = 2;
  localparam int LANE_DAMP  = 3;
  localparam int LANE_TORQ  = 4;

  typedef enum logic [2:0] {
    REG_POSITION_LIMIT = 3'd0,
    REG_VELOCITY_LIMIT = 3'd1,
    REG_TORQUE_LIMIT   = 3'd2,
    REG_STIFFNESS_LOW  = 3'd3,
    REG_STIFFNESS_HIGH = 3'd4,
    REG_DAMPING_LOW    = 3'd5,
    REG_DAMPING_HIGH   = 3'd6
  } cfg_reg_t;

  typedef logic [NUM_LANES-1:0][SPAN_W-1:0] lane_span_t;
  typedef logic [NUM_LANES-1:0][DATA_W-1:0] lane_value_t;

  typedef struct packed {
    logic [SPAN_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    logic                             valid;
    logic [NUM_LANES-1:0]             zero;
    logic [NUM_LANES-1:0]             full;
    div_lane_t [NUM_LANES-1:0]        lane;
  } div_stage_t;

  function automatic int unsigned lane_bits(input int unsigned lane);
    lane_bits = (lane == LANE_POS) ? POSITION_BITS : GAIN_BITS;
  endfunction

  function automatic logic [QUO_W-1:0] lane_top(input int unsigned lane);
    lane_top = QUO_W'((1 << lane_bits(lane)) - 1);
  endfunction

endpackage

### hw/rtl/mcfp_prep.sv
// ----------------------------------------------------------------------------
// Motor command frame packer input stage
// Offsets each value by its range floor, flags below/above range and forms
// the scaled dividend offset * (2^bits - 1) for the divider chain.
// ----------------------------------------------------------------------------
module mcfp_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  mcfp_pkg::lane_value_t value,
  input  mcfp_pkg::lane_span_t  lo,
  input  mcfp_pkg::lane_span_t  span,
  input  logic                stall_in,
  output mcfp_pkg::div_stage_t  stage,
  output logic                stall_out
);
  import mcfp_pkg::*;

  div_stage_t                          stage_next;
  logic [NUM_LANES-1:0][DIFF_W-1:0]    diff;
  logic [NUM_LANES-1:0][NUM_W-1:0]     d_wide;
  logic [NUM_LANES-1:0][NUM_W-1:0]     num;

  assign stall_out = stage.valid && stall_in;

  always_comb begin
    stage_next       = '0;
    stage_next.valid = cmd_valid;
    for (int i = 0; i < NUM_LANES; i++) begin
      diff[i] = {{(DIFF_W-DATA_W){value[i][DATA_W-1]}}, value[i]} -
                {lo[i][SPAN_W-1], lo[i]};
      stage_next.zero[i] = span[i][SPAN_W-1] || (span[i] == '0) ||
                           diff[i][DIFF_W-1] || (diff[i] == '0);
      stage_next.full[i] = !stage_next.zero[i] && (diff[i] >= {1'b0, span[i]});
      d_wide[i] = {{QUO_W{1'b0}}, diff[i][SPAN_W-1:0]};
      num[i]    = (d_wide[i] << lane_bits(i)) - d_wide[i];
      stage_next.lane[i].rem = num[i][NUM_W-1:QUO_W];
      stage_next.lane[i].low = num[i][QUO_W-1:0];
      stage_next.lane[i].quo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stage <= '0;
    else if (!stall_out) stage <= stage_next;
  end

endmodule

### hw/rtl/mcfp_div_cell.sv
// ----------------------------------------------------------------------------
// Motor command frame packer divider cell
// One restoring division step for all five lanes: shift in a dividend bit,
// trial-subtract the span, emit one quotient bit.
// ----------------------------------------------------------------------------
module mcfp_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  mcfp_pkg::div_stage_t  up,
  input  mcfp_pkg::lane_span_t  span,
  input  logic                stall_in,
  output mcfp_pkg::div_stage_t  stage,
  output logic                stall_out
);
  import mcfp_pkg::*;

  div_stage_t                        stage_next;
  logic [NUM_LANES-1:0][SPAN_W:0]    trial;
  logic [NUM_LANES-1:0][SPAN_W:0]    diff;
  logic [NUM_LANES-1:0]              ge;

  assign stall_out = stage.valid && stall_in;

  always_comb begin
    stage_next = up;
    for (int i = 0; i < NUM_LANES; i++) begin
      trial[i] = {up.lane[i].rem, up.lane[i].low[QUO_W-1]};
      ge[i]    = trial[i] >= {1'b0, span[i]};
      diff[i]  = trial[i] - {1'b0, span[i]};
      stage_next.lane[i].rem = ge[i] ? diff[i][SPAN_W-1:0] : trial[i][SPAN_W-1:0];
      stage_next.lane[i].low = up.lane[i].low << 1;
      stage_next.lane[i].quo = {up.lane[i].quo[QUO_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stage <= '0;
    else if (!stall_out) stage <= stage_next;
  end

endmodule

### hw/rtl/motor_command_frame_packer.sv
// ----------------------------------------------------------------------------
// Motor command frame packer
// Quantizes a five-value motor command against configured ranges and packs
// the codes big-endian into an 8-byte CAN payload.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: cmd_valid/cmd_stall with target_position, target_velocity,
//   stiffness, damping, feedforward_torque (signed Q16.16). A transaction
//   happens on a rising edge with cmd_valid high and cmd_stall low.
//   Frame channel: frame_valid/frame_stall with frame_byte_0..7.
//   Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects the
//   register, cfg_data the value; write only while no command is in flight.
//   Throughput: one command per cycle while the frame channel is not stalled.
//   A command passes through the input stage, a chain of 16 one-bit divider
//   cells and the output register before frame_valid rises.
//   Reset clears all stage valids and loads the default ranges; no clearing
//   pass is needed. When the receiver stalls, the held frame stays and
//   stages behind it keep moving until they fill; cmd_stall rises only when
//   the input stage is occupied and cannot advance.
// ----------------------------------------------------------------------------
`include "motor_command_frame_packer_macros.svh"

module motor_command_frame_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [mcfp_pkg::DATA_W-1:0]   target_position,
  input  logic [mcfp_pkg::DATA_W-1:0]   target_velocity,
  input  logic [mcfp_pkg::DATA_W-1:0]   stiffness,
  input  logic [mcfp_pkg::DATA_W-1:0]   damping,
  input  logic [mcfp_pkg::DATA_W-1:0]   feedforward_torque,
  output logic                          frame_valid,
  input  logic                          frame_stall,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_0,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_1,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_2,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_3,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_4,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_5,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_6,
  output logic [mcfp_pkg::BYTE_W-1:0]   frame_byte_7,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [mcfp_pkg::DATA_W-1:0]   cfg_data
);
  import mcfp_pkg::*;

  lane_span_t                       lo;
  lane_span_t                       span;
  logic [DATA_W-1:0]                stiff_high;
  logic [DATA_W-1:0]                damp_high;
  lane_value_t                      value;
  div_stage_t                       chain [NUM_STEPS+1];
  logic [NUM_STEPS:0]               upstall;
  logic [NUM_LANES-1:0][CODE_W-1:0] code;
  logic [SPAN_W-1:0]                cfg_sext;

  assign cfg_ready = 1'b1;
  assign cfg_sext  = {cfg_data[DATA_W-1], cfg_data};

  // range floor and span per lane, updated on the write itself
  always_ff @(posedge clk) begin
    if (rst) begin
      lo[LANE_POS]     <= SPAN_W'(-819200);
      span[LANE_POS]   <= SPAN_W'(1638400);
      lo[LANE_VEL]     <= SPAN_W'(-1966080);
      span[LANE_VEL]   <= SPAN_W'(3932160);
      lo[LANE_TORQ]    <= SPAN_W'(-655360);
      span[LANE_TORQ]  <= SPAN_W'(1310720);
      lo[LANE_STIFF]   <= '0;
      span[LANE_STIFF] <= SPAN_W'(32768000);
      stiff_high       <= DATA_W'(32768000);
      lo[LANE_DAMP]    <= '0;
      span[LANE_DAMP]  <= SPAN_W'(327680);
      damp_high        <= DATA_W'(327680);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POSITION_LIMIT: begin
          lo[LANE_POS]   <= -{2'b00, cfg_data[LIMIT_W-1:0]};
          span[LANE_POS] <= {1'b0, cfg_data[LIMIT_W-1:0], 1'b0};
        end
        REG_VELOCITY_LIMIT: begin
          lo[LANE_VEL]   <= -{2'b00, cfg_data[LIMIT_W-1:0]};
          span[LANE_VEL] <= {1'b0, cfg_data[LIMIT_W-1:0], 1'b0};
        end
        REG_TORQUE_LIMIT: begin
          lo[LANE_TORQ]   <= -{2'b00, cfg_data[LIMIT_W-1:0]};
          span[LANE_TORQ] <= {1'b0, cfg_data[LIMIT_W-1:0], 1'b0};
        end
        REG_STIFFNESS_LOW: begin
          lo[LANE_STIFF]   <= cfg_sext;
          span[LANE_STIFF] <= {stiff_high[DATA_W-1], stiff_high} - cfg_sext;
        end
        REG_STIFFNESS_HIGH: begin
          stiff_high       <= cfg_data;
          span[LANE_STIFF] <= cfg_sext - lo[LANE_STIFF];
        end
        REG_DAMPING_LOW: begin
          lo[LANE_DAMP]   <= cfg_sext;
          span[LANE_DAMP] <= {damp_high[DATA_W-1], damp_high} - cfg_sext;
        end
        REG_DAMPING_HIGH: begin
          damp_high       <= cfg_data;
          span[LANE_DAMP] <= cfg_sext - lo[LANE_DAMP];
        end
        default: ;
      endcase
    end
  end

  assign value[LANE_POS]   = target_position;
  assign value[LANE_VEL]   = target_velocity;
  assign value[LANE_STIFF] = stiffness;
  assign value[LANE_DAMP]  = damping;
  assign value[LANE_TORQ]  = feedforward_torque;

  mcfp_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .value     (value),
    .lo        (lo),
    .span      (span),
    .stall_in  (upstall[0]),
    .stage     (chain[0]),
    .stall_out (cmd_stall)
  );

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_cell
    mcfp_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .up        (chain[k]),
      .span      (span),
      .stall_in  (upstall[k+1]),
      .stage     (chain[k+1]),
      .stall_out (upstall[k])
    );
  end

  assign upstall[NUM_STEPS] = frame_valid && frame_stall;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (chain[NUM_STEPS].zero[i]) code[i] = '0;
      else if (chain[NUM_STEPS].full[i]) code[i] = CODE_W'(lane_top(i));
      else code[i] = CODE_W'(chain[NUM_STEPS].lane[i].quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!upstall[NUM_STEPS]) begin
      frame_valid <= chain[NUM_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!upstall[NUM_STEPS]) begin
      frame_byte_0 <= code[LANE_POS][15:8];
      frame_byte_1 <= code[LANE_POS][7:0];
      frame_byte_2 <= code[LANE_VEL][11:4];
      frame_byte_3 <= {code[LANE_VEL][3:0], code[LANE_STIFF][11:8]};
      frame_byte_4 <= code[LANE_STIFF][7:0];
      frame_byte_5 <= code[LANE_DAMP][11:4];
      frame_byte_6 <= {code[LANE_DAMP][3:0], code[LANE_TORQ][11:8]};
      frame_byte_7 <= code[LANE_TORQ][7:0];
    end
  end

  `MCFP_ASSERT_IMP(a_stall_needs_occupied, clk, rst, cmd_stall, chain[0].valid, "stall with empty input stage")
  `MCFP_ASSERT_IMP(a_flags_exclusive, clk, rst, chain[NUM_STEPS].valid, (chain[NUM_STEPS].zero & chain[NUM_STEPS].full) == '0, "lane both empty and full")
  `MCFP_ASSERT_IMP(a_pos_rem_bound, clk, rst, chain[NUM_STEPS].valid && !chain[NUM_STEPS].zero[LANE_POS] && !chain[NUM_STEPS].full[LANE_POS], chain[NUM_STEPS].lane[LANE_POS].rem < span[LANE_POS], "position remainder not below span")
  `MCFP_ASSERT_IMP(a_torq_rem_bound, clk, rst, chain[NUM_STEPS].valid && !chain[NUM_STEPS].zero[LANE_TORQ] && !chain[NUM_STEPS].full[LANE_TORQ], chain[NUM_STEPS].lane[LANE_TORQ].rem < span[LANE_TORQ], "torque remainder not below span")
  `MCFP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !frame_valid && !cmd_stall, "pipeline not empty after reset")

endmodule
